// File: sv/pfns_pkg.sv
package pfns_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] time_ms;
      logic [15:0] pitch_freq;
      logic [15:0] pitch_conf;
      logic [15:0] level_rms;
      logic        onset_flag;
   } req_type;

   typedef struct packed {
      logic [6:0]  note_number;
      logic [31:0] start_beats;
      logic [31:0] length_beats;
      logic [15:0] velocity;
   } rsp_type;

   localparam logic [1:0] MODE_FRAME = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   localparam logic [1:0] CSR_TEMPO   = 2'd0;
   localparam logic [1:0] CSR_VCONF   = 2'd1;
   localparam logic [1:0] CSR_LOWEST  = 2'd2;
   localparam logic [1:0] CSR_SILENCE = 2'd3;

   localparam logic [7:0]  TEMPO_MIN     = 8'd40;
   localparam logic [7:0]  TEMPO_MAX     = 8'd240;
   localparam logic [7:0]  TEMPO_RESET   = 8'd120;
   localparam logic [15:0] VCONF_RESET   = 16'd16384;
   localparam logic [15:0] LOWEST_RESET  = 16'd1040;
   localparam logic [15:0] SILENCE_RESET = 16'd786;
   localparam logic [31:0] MIN_LENGTH    = 32'd32;

   // ms * tempo * 256 / 60000 == (ms * tempo * 32) / 7500
   localparam logic [13:0] BEAT_DIVISOR = 14'd7500;
   localparam int          PROD_W       = 40;
   localparam int          DIVIDEND_W   = PROD_W + 5;

   localparam logic [3:0] LAST_EDGE = 4'd11;

   function automatic logic [15:0] semitone_edge(input logic [3:0] k);
      logic [15:0] e;
      unique case (k)
         4'd0:    e = 16'd34470;
         4'd1:    e = 16'd36520;
         4'd2:    e = 16'd38691;
         4'd3:    e = 16'd40992;
         4'd4:    e = 16'd43429;
         4'd5:    e = 16'd46012;
         4'd6:    e = 16'd48748;
         4'd7:    e = 16'd51646;
         4'd8:    e = 16'd54717;
         4'd9:    e = 16'd57971;
         4'd10:   e = 16'd61418;
         4'd11:   e = 16'd65070;
         default: e = 16'hFFFF;
      endcase
      return e;
   endfunction

endpackage

// File: sv/pfns_note.sv
module pfns_note (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] freq,
   output logic        done,
   output logic [6:0]  note
);

   typedef enum logic [2:0] {
      N_IDLE = 3'b001,
      N_NORM = 3'b010,
      N_CNT  = 3'b100
   } nstate_type;

   nstate_type  state_ff, state_in;
   logic [15:0] norm_ff, norm_in;
   logic [3:0]  shift_ff, shift_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  k_ff, k_in;
   logic [6:0]  note_ff, note_in;
   logic        done_ff, done_in;
   logic [7:0]  base;
   logic [7:0]  sub;

   always_comb begin
      state_in = state_ff;
      norm_in  = norm_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      note_in  = note_ff;
      done_in  = 1'b0;
      base     = 8'd0;
      sub      = 8'd0;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               if (freq == 16'd0) begin
                  note_in = 7'd0;
                  done_in = 1'b1;
               end else begin
                  norm_in  = freq;
                  shift_in = 4'd0;
                  cnt_in   = 4'd0;
                  k_in     = 4'd0;
                  state_in = N_NORM;
               end
            end
         end
         N_NORM: begin
            // normalize one bit a cycle
            if (norm_ff[15]) begin
               state_in = N_CNT;
            end else begin
               norm_in  = {norm_ff[14:0], 1'b0};
               shift_in = shift_ff + 4'd1;
            end
         end
         N_CNT: begin
            if (norm_ff >= pfns_pkg::semitone_edge(k_ff)) begin
               cnt_in = cnt_ff + 4'd1;
            end
            k_in = k_ff + 4'd1;
            if (k_ff == pfns_pkg::LAST_EDGE) begin
               base = 8'd96 + {4'd0, cnt_in};
               sub  = {4'd0, shift_ff} * 8'd12;
               note_in  = (sub > base) ? 7'd0 : 7'(base - sub);
               done_in  = 1'b1;
               state_in = N_IDLE;
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      norm_ff  <= norm_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      note_ff  <= note_in;
   end

   assign done = done_ff;
   assign note = note_ff;

endmodule

// File: sv/pfns_conv.sv
module pfns_conv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] diff,
   input  logic [7:0]  tempo,
   output logic        done,
   output logic [31:0] units
);

   localparam int PW = pfns_pkg::PROD_W;
   localparam int DW = pfns_pkg::DIVIDEND_W;

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_MUL  = 3'b010,
      C_DIV  = 3'b100
   } cstate_type;

   cstate_type    state_ff, state_in;
   logic [31:0]   diff_ff, diff_in;
   logic [7:0]    tempo_ff, tempo_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [DW-1:0] dq_ff, dq_in;
   logic [12:0]   rem_ff, rem_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [13:0]   trial;
   logic          qbit;

   always_comb begin
      state_in = state_ff;
      diff_in  = diff_ff;
      tempo_in = tempo_ff;
      acc_in   = acc_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, dq_ff[DW-1]};
      qbit     = trial >= pfns_pkg::BEAT_DIVISOR;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               diff_in  = diff;
               tempo_in = tempo;
               acc_in   = '0;
               cnt_in   = 6'd0;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            // shift-add, tempo MSB first
            acc_in   = {acc_ff[PW-2:0], 1'b0} +
                       (tempo_ff[7] ? {{(PW-32){1'b0}}, diff_ff} : '0);
            tempo_in = {tempo_ff[6:0], 1'b0};
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd7) begin
               dq_in    = {acc_in, 5'd0};
               rem_in   = 13'd0;
               cnt_in   = 6'd0;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = qbit ? 13'(trial - pfns_pkg::BEAT_DIVISOR) : trial[12:0];
            dq_in  = {dq_ff[DW-2:0], qbit};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DW - 1)) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      diff_ff  <= diff_in;
      tempo_ff <= tempo_in;
      acc_ff   <= acc_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign done  = done_ff;
   assign units = (|dq_ff[DW-1:32]) ? 32'hFFFF_FFFF : dq_ff[31:0];

endmodule

// File: sv/pitch_frame_note_segmenter.sv
// Start, stop without a note and ignored items pass dispatch only; unvoiced
// frames also evaluation; voiced frames first the note lookup (bit-serial
// normalize, then one semitone edge per cycle). A finished note uses the
// bit-serial beat converters (8 multiply, 45 divide steps) and waits for the
// output register. One item at a time: the next is taken once the previous one
// is done. Synchronous reset clears control state and restores register defaults.
module pitch_frame_note_segmenter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfns_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfns_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DISP = 5'b00010,
      S_NOTE = 5'b00100,
      S_EVAL = 5'b01000,
      S_CONV = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   pfns_pkg::req_type item_ff;
   logic [7:0]        tempo_ff;
   logic [15:0]       vconf_ff, lowest_ff, silence_ff;
   logic              recording_ff, recording_in;
   logic              open_ff, open_in;
   logic [6:0]        open_note_ff, open_note_in;
   logic [31:0]       phrase_start_ff, phrase_start_in;
   logic [31:0]       note_start_ff, note_start_in;
   logic [15:0]       peak_ff, peak_in;
   logic [7:0]        phrase_tempo_ff, phrase_tempo_in;
   logic [6:0]        res_note_ff, res_note_in;
   logic [15:0]       res_vel_ff, res_vel_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff;
   pfns_pkg::rsp_type rsp_data_ff;

   logic        voiced, silent, changed, do_close, open_after;
   logic [6:0]  note_val;
   logic [15:0] vel;
   logic [31:0] len_diff, start_diff;
   logic        note_start_go, conv_go;
   logic        note_done, len_done, start_done;
   logic [6:0]  note_q;
   logic [31:0] len_units, start_units;
   logic [7:0]  tempo_clamped;
   logic        out_load;

   assign voiced = (item_ff.pitch_conf >= vconf_ff) && (item_ff.pitch_freq >= lowest_ff);
   assign silent = !voiced && (item_ff.level_rms < silence_ff);
   assign note_val = voiced ? note_q : 7'd0;
   assign changed = open_ff && voiced && (note_val != open_note_ff);
   assign vel = (|item_ff.level_rms[15:13]) ? 16'hFFFF : {item_ff.level_rms[12:0], 3'd0};
   assign len_diff = (item_ff.time_ms >= note_start_ff) ? item_ff.time_ms - note_start_ff
                                                       : 32'd0;
   assign start_diff = (note_start_ff >= phrase_start_ff) ? note_start_ff - phrase_start_ff
                                                          : 32'd0;

   always_comb begin
      state_in        = state_ff;
      recording_in    = recording_ff;
      open_in         = open_ff;
      open_note_in    = open_note_ff;
      phrase_start_in = phrase_start_ff;
      note_start_in   = note_start_ff;
      peak_in         = peak_ff;
      phrase_tempo_in = phrase_tempo_ff;
      res_note_in     = res_note_ff;
      res_vel_in      = res_vel_ff;
      pend_in         = pend_ff;
      note_start_go   = 1'b0;
      conv_go         = 1'b0;
      do_close        = 1'b0;
      open_after      = open_ff;
      out_load        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_IDLE;
            priority if (item_ff.mode == pfns_pkg::MODE_START) begin
               open_in         = 1'b0;
               peak_in         = 16'd0;
               open_note_in    = 7'd0;
               recording_in    = 1'b1;
               phrase_tempo_in = tempo_ff;
               phrase_start_in = item_ff.time_ms;
               note_start_in   = item_ff.time_ms;
            end else if (item_ff.mode == pfns_pkg::MODE_STOP) begin
               if (recording_ff) begin
                  recording_in = 1'b0;
                  do_close     = open_ff;
               end
            end else if (item_ff.mode == pfns_pkg::MODE_FRAME && recording_ff) begin
               if (voiced) begin
                  note_start_go = 1'b1;
                  state_in      = S_NOTE;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_NOTE: begin
            if (note_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in   = S_IDLE;
            do_close   = open_ff && (changed || silent || item_ff.onset_flag);
            open_after = do_close ? 1'b0 : open_ff;
            if (voiced && !open_after) begin
               open_in       = 1'b1;
               open_note_in  = note_val;
               note_start_in = item_ff.time_ms;
               peak_in       = vel;
            end else if (voiced && vel > peak_ff) begin
               peak_in = vel;
            end
         end
         S_CONV: begin
            if (len_done) begin
               pend_in = 1'b1;
            end
            // hold the finished item until the output register frees up
            if ((pend_ff || len_done) && (!rsp_valid_ff || !rsp_stall)) begin
               out_load = 1'b1;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (do_close) begin
         res_note_in = open_note_ff;
         res_vel_in  = peak_ff;
         conv_go     = 1'b1;
         state_in    = S_CONV;
         if (state_ff == S_DISP) begin
            open_in = 1'b0;
            peak_in = 16'd0;
         end else if (!voiced) begin
            open_in = 1'b0;
            peak_in = 16'd0;
         end
      end
   end

   pfns_note u_note (
      .clock (clock),
      .reset (reset),
      .start (note_start_go),
      .freq  (item_ff.pitch_freq),
      .done  (note_done),
      .note  (note_q)
   );

   pfns_conv u_len_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_go),
      .diff  (len_diff),
      .tempo (phrase_tempo_ff),
      .done  (len_done),
      .units (len_units)
   );

   pfns_conv u_start_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_go),
      .diff  (start_diff),
      .tempo (phrase_tempo_ff),
      .done  (start_done),
      .units (start_units)
   );

   assign tempo_clamped = (csr_wdata[7:0] < pfns_pkg::TEMPO_MIN) ? pfns_pkg::TEMPO_MIN :
                          (csr_wdata[7:0] > pfns_pkg::TEMPO_MAX) ? pfns_pkg::TEMPO_MAX :
                          csr_wdata[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         tempo_ff        <= pfns_pkg::TEMPO_RESET;
         vconf_ff        <= pfns_pkg::VCONF_RESET;
         lowest_ff       <= pfns_pkg::LOWEST_RESET;
         silence_ff      <= pfns_pkg::SILENCE_RESET;
         recording_ff    <= 1'b0;
         open_ff         <= 1'b0;
         open_note_ff    <= 7'd0;
         phrase_start_ff <= 32'd0;
         note_start_ff   <= 32'd0;
         peak_ff         <= 16'd0;
         phrase_tempo_ff <= pfns_pkg::TEMPO_RESET;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         recording_ff    <= recording_in;
         open_ff         <= open_in;
         open_note_ff    <= open_note_in;
         phrase_start_ff <= phrase_start_in;
         note_start_ff   <= note_start_in;
         peak_ff         <= peak_in;
         phrase_tempo_ff <= phrase_tempo_in;
         pend_ff         <= pend_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               pfns_pkg::CSR_TEMPO:   tempo_ff   <= tempo_clamped;
               pfns_pkg::CSR_VCONF:   vconf_ff   <= csr_wdata;
               pfns_pkg::CSR_LOWEST:  lowest_ff  <= csr_wdata;
               pfns_pkg::CSR_SILENCE: silence_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      res_note_ff <= res_note_in;
      res_vel_ff  <= res_vel_in;
      if (out_load) begin
         rsp_data_ff.note_number  <= res_note_ff;
         rsp_data_ff.start_beats  <= start_units;
         rsp_data_ff.length_beats <= (len_units < pfns_pkg::MIN_LENGTH) ?
                                     pfns_pkg::MIN_LENGTH : len_units;
         rsp_data_ff.velocity     <= res_vel_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_conv_lockstep: assert property (@(posedge clock) disable iff (reset)
      len_done == start_done)
      else $error("beat converters out of step");

   a_open_needs_phrase: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> recording_ff)
      else $error("note open outside a phrase");

   a_peak_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> peak_ff == 16'd0)
      else $error("peak velocity left over without an open note");

   a_rsp_from_conv: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_CONV))
      else $error("result raised outside conversion");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   pfns_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   pfns_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [15:0]       csr_wdata;

   pitch_frame_note_segmenter DUT (.*);

   // note segmentation predictor and queue of pending note events
   class note_board;
      logic [7:0]  tempo_reg;
      logic [15:0] vconf_reg, lowest_reg, silence_reg;
      bit          recording, note_open;
      logic [6:0]  open_note;
      logic [31:0] phrase_ms, note_ms;
      logic [15:0] peak_vel;
      logic [7:0]  phrase_tempo;
      pfns_pkg::rsp_type pending[$];
      int          errors;

      function void clear();
         tempo_reg = pfns_pkg::TEMPO_RESET;
         vconf_reg = pfns_pkg::VCONF_RESET;
         lowest_reg = pfns_pkg::LOWEST_RESET;
         silence_reg = pfns_pkg::SILENCE_RESET;
         recording = 0;
         note_open = 0;
         open_note = 0;
         phrase_ms = 0;
         note_ms = 0;
         peak_vel = 0;
         phrase_tempo = pfns_pkg::TEMPO_RESET;
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            pfns_pkg::CSR_TEMPO: begin
               if (val[7:0] < pfns_pkg::TEMPO_MIN) tempo_reg = pfns_pkg::TEMPO_MIN;
               else if (val[7:0] > pfns_pkg::TEMPO_MAX) tempo_reg = pfns_pkg::TEMPO_MAX;
               else tempo_reg = val[7:0];
            end
            pfns_pkg::CSR_VCONF:   vconf_reg = val;
            pfns_pkg::CSR_LOWEST:  lowest_reg = val;
            pfns_pkg::CSR_SILENCE: silence_reg = val;
         endcase
      endfunction

      function logic [6:0] note_of(logic [15:0] f);
         int sh, cnt, n;
         logic [15:0] nf;
         int edges[12] = '{34470, 36520, 38691, 40992, 43429, 46012,
                           48748, 51646, 54717, 57971, 61418, 65070};
         sh = 0;
         cnt = 0;
         nf = f;
         if (f == 0) return 0;
         while (nf < 16'h8000) begin
            nf = nf << 1;
            sh++;
         end
         for (int k = 0; k < 12; k++) if (nf >= edges[k]) cnt++;
         n = 96 - 12 * sh + cnt;
         if (n < 0) n = 0;
         if (n > 127) n = 127;
         return n[6:0];
      endfunction

      function logic [31:0] to_beats(logic [31:0] later, logic [31:0] earlier);
         logic [63:0] d;
         d = (later >= earlier) ? 64'(later - earlier) : 64'd0;
         d = d * phrase_tempo * 256 / 60000;
         return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
      endfunction

      function void finish_note(logic [31:0] t);
         pfns_pkg::rsp_type r;
         r.note_number = open_note;
         r.start_beats = to_beats(note_ms, phrase_ms);
         r.length_beats = to_beats(t, note_ms);
         if (r.length_beats < pfns_pkg::MIN_LENGTH) r.length_beats = pfns_pkg::MIN_LENGTH;
         r.velocity = peak_vel;
         pending = {pending, r};
         note_open = 0;
         peak_vel = 0;
      endfunction

      function void note_item(pfns_pkg::req_type q);
         bit voiced, silent, changed;
         logic [6:0]  n;
         logic [19:0] v;
         logic [15:0] vel;
         n = 0;
         if (q.mode == pfns_pkg::MODE_START) begin
            note_open = 0;
            peak_vel = 0;
            open_note = 0;
            recording = 1;
            phrase_tempo = tempo_reg;
            phrase_ms = q.time_ms;
            note_ms = q.time_ms;
            return;
         end
         if (q.mode == pfns_pkg::MODE_STOP) begin
            if (!recording) return;
            if (note_open) finish_note(q.time_ms);
            recording = 0;
            return;
         end
         if (q.mode != pfns_pkg::MODE_FRAME || !recording) return;
         voiced = q.pitch_conf >= vconf_reg && q.pitch_freq >= lowest_reg;
         if (voiced) n = note_of(q.pitch_freq);
         changed = note_open && voiced && n != open_note;
         silent = !voiced && q.level_rms < silence_reg;
         if (note_open && (changed || silent || q.onset_flag)) finish_note(q.time_ms);
         v = {1'b0, q.level_rms, 3'b0};
         vel = (v > 20'hFFFF) ? 16'hFFFF : v[15:0];
         if (voiced && !note_open) begin
            note_open = 1;
            open_note = n;
            note_ms = q.time_ms;
            peak_vel = vel;
         end else if (voiced && vel > peak_vel) peak_vel = vel;
      endfunction

      function void check_note(pfns_pkg::rsp_type a);
         pfns_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected note event %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.note_number !== e.note_number) begin
            $error("note_number exp %0d got %0d", e.note_number, a.note_number);
            errors++;
         end
         if (a.start_beats !== e.start_beats) begin
            $error("start_beats exp %0d got %0d", e.start_beats, a.start_beats);
            errors++;
         end
         if (a.length_beats !== e.length_beats) begin
            $error("length_beats exp %0d got %0d", e.length_beats, a.length_beats);
            errors++;
         end
         if (a.velocity !== e.velocity) begin
            $error("velocity exp %0d got %0d", e.velocity, a.velocity);
            errors++;
         end
      endfunction
   endclass

   note_board board;
   int  send_idle_pct, stall_pct;
   bit  hold_off;
   int  quiet_cycles;
   logic [31:0] clock_ms;
   logic [15:0] base_freq;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver side: random stall, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_note(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // valid stays up after an accepted item until the next gap, a register write or a drain
   task automatic send(pfns_pkg::req_type q);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(q);
   endtask

   task automatic send_mode(logic [1:0] m, logic [31:0] t);
      pfns_pkg::req_type q;
      q = '0;
      q.mode = m;
      q.time_ms = t;
      q.pitch_freq = 16'($urandom);
      q.pitch_conf = 16'($urandom);
      q.level_rms = 16'($urandom);
      q.onset_flag = 1'($urandom);
      send(q);
   endtask

   task automatic send_frame(logic [31:0] t, logic [15:0] f, logic [15:0] c,
                             logic [15:0] r, logic o);
      pfns_pkg::req_type q;
      q.mode = pfns_pkg::MODE_FRAME;
      q.time_ms = t;
      q.pitch_freq = f;
      q.pitch_conf = c;
      q.level_rms = r;
      q.onset_flag = o;
      send(q);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one random frame, mostly near the current pitch so notes get long
   task automatic random_frame();
      int k;
      logic [15:0] f;
      k = $urandom_range(99);
      f = base_freq;
      if (k < 15) base_freq = 16'($urandom_range(65535));
      else if (k < 25) f = 16'(base_freq + $urandom_range(30));
      clock_ms = clock_ms + $urandom_range(40);
      if ($urandom_range(99) < 2) clock_ms = $urandom;
      if (k < 85)
         send_frame(clock_ms, f, 16'($urandom_range(65535, 20000)), 16'($urandom),
                    $urandom_range(99) < 8);
      else
         send_frame(clock_ms, 16'($urandom), 16'($urandom), 16'($urandom_range(2000)),
                    1'($urandom_range(1)));
   endtask

   task automatic phrase(int frames);
      clock_ms = $urandom_range(99) < 10 ? $urandom : $urandom_range(100000);
      send_mode(pfns_pkg::MODE_START, clock_ms);
      for (int i = 0; i < frames; i++) random_frame();
      if ($urandom_range(99) < 90)
         send_mode(pfns_pkg::MODE_STOP, clock_ms + $urandom_range(500));
   endtask

   initial begin
      int k;
      board = new();
      board.clear();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = pfns_pkg::CSR_TEMPO;
      csr_wdata = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      base_freq = 16'd7040;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: idle items, extremes, onset on same pitch, start restart
      send_mode(pfns_pkg::MODE_STOP, 32'd5);
      send_frame(32'd6, 16'd7040, 16'hFFFF, 16'hFFFF, 1'b0);
      send_mode(MODE_UNUSED, 32'd7);
      send_mode(pfns_pkg::MODE_START, 32'd0);
      send_frame(32'd10, 16'd7040, 16'hFFFF, 16'hFFFF, 1'b0);
      send_frame(32'd20, 16'd7040, 16'hFFFF, 16'd100, 1'b1);
      send_frame(32'd3000, 16'd7100, 16'hFFFF, 16'd0, 1'b0);
      send_frame(32'd3001, 16'hFFFF, 16'hFFFF, 16'd10, 1'b0);
      send_frame(32'd3002, 16'd0, 16'd0, 16'd0, 1'b0);
      send_frame(32'd3003, 16'd1040, 16'd16384, 16'd900, 1'b0);
      send_frame(32'd3004, 16'd5000, 16'd0, 16'd900, 1'b0);
      send_frame(32'd2, 16'd2000, 16'hFFFF, 16'd900, 1'b0);
      send_mode(pfns_pkg::MODE_START, 32'd50);
      send_frame(32'hFFFF_FFFF, 16'd20000, 16'hFFFF, 16'd9000, 1'b0);
      send_mode(pfns_pkg::MODE_STOP, 32'd0);
      send_mode(pfns_pkg::MODE_START, 32'd0);
      send_frame(32'd0, 16'd30000, 16'hFFFF, 16'd9000, 1'b0);
      send_mode(pfns_pkg::MODE_STOP, 32'hFFFF_FFFF);
      drain();
      write_csr(pfns_pkg::CSR_TEMPO, 16'hFFFF);
      write_csr(pfns_pkg::CSR_VCONF, 16'd0);
      write_csr(pfns_pkg::CSR_LOWEST, 16'd1);
      write_csr(pfns_pkg::CSR_SILENCE, 16'hFFFF);
      send_mode(pfns_pkg::MODE_START, 32'd0);
      send_frame(32'd1, 16'd1, 16'd0, 16'd0, 1'b0);
      send_frame(32'hFFFF_FFFF, 16'd2, 16'd0, 16'd0, 1'b0);
      drain();
      write_csr(pfns_pkg::CSR_TEMPO, 16'd0);
      send_mode(pfns_pkg::MODE_STOP, 32'hFFFF_FFFF);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 84 : 35) : 0;
         stall_pct = (p == 2) ? 84 : (p == 3 ? 35 : 0);
         k = $urandom_range(3);
         write_csr(pfns_pkg::CSR_TEMPO,
                   16'(k == 0 ? 16'd40 : k == 1 ? 16'd240 : $urandom_range(255)));
         write_csr(pfns_pkg::CSR_VCONF, 16'(k == 0 ? 16'hFFF0 : $urandom_range(30000)));
         write_csr(pfns_pkg::CSR_LOWEST, 16'(k == 1 ? 16'd0 : $urandom_range(3000)));
         write_csr(pfns_pkg::CSR_SILENCE, 16'(k == 2 ? 16'd0 : $urandom_range(2000)));
         if (p == 0) begin
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (3000) @(posedge clock);
                  hold_off <= 1'b0;
               end
               repeat (4) phrase(12);
            join
         end
         while (quiet_cycles >= 0 && k < 640) begin
            phrase($urandom_range(30, 2));
            k = k + 30;
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule

// File: sim.f
sv/pfns_pkg.sv
sv/pfns_note.sv
sv/pfns_conv.sv
sv/pitch_frame_note_segmenter.sv
tb/sv/tb.sv
